/* design/lpp_pkg.sv */
// ----------------------------------------------------------------------------
// lpp_pkg
// Shared constants, command and status types of the packet point parser.
// ----------------------------------------------------------------------------
package lpp_pkg;

	localparam int POINTS_PER_PACKET = 32;
	localparam int PACKET_LENGTH     = 108;

	localparam int PT_AW  = (POINTS_PER_PACKET > 1) ? $clog2(POINTS_PER_PACKET) : 1;
	localparam int PT_CW  = $clog2(POINTS_PER_PACKET + 1);
	localparam int POS_W  = 8;

	localparam logic [POS_W:0]   END_FIELD  = (POS_W + 1)'(PACKET_LENGTH - 3);
	localparam logic [16:0]      ANGLE_WRAP = 17'd36000;
	localparam logic [7:0]       HDR_FIRST  = 8'hA5;
	localparam logic [7:0]       HDR_SECOND = 8'h5A;
	localparam logic [7:0]       LEN_BYTE   = 8'(PACKET_LENGTH);

	localparam logic [2:0] CFG_ANGLE_LOW  = 3'd0;
	localparam logic [2:0] CFG_ANGLE_HIGH = 3'd1;
	localparam logic [2:0] CFG_DIST_LOW   = 3'd2;
	localparam logic [2:0] CFG_DIST_HIGH  = 3'd3;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_PER_H,
		OP_PER_L,
		OP_SA_H,
		OP_SA_L,
		OP_DIST_H,
		OP_DIST_L,
		OP_POINT,
		OP_EA_H,
		OP_EA_L,
		OP_CHECK
	} byte_op_t;

	typedef struct packed {
		logic             sum_begin;
		logic             sum_add;
		logic             sum_clear;
		byte_op_t         op;
		logic [PT_AW-1:0] addr;
		logic             rd;
		logic             emit;
		logic             last;
		logic             bad;
	} lpp_cmd_t;

	typedef struct packed {
		logic is_first;
		logic is_second;
		logic len_ok;
		logic sum_ok;
		logic out_free;
	} lpp_sts_t;

endpackage

/* design/lpp_ctrl.sv */
// ----------------------------------------------------------------------------
// lpp_ctrl
// Packet framing state machine and point emission sequencer.
// ----------------------------------------------------------------------------
module lpp_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  lpp_pkg::lpp_sts_t  sts,
	output lpp_pkg::lpp_cmd_t  cmd
);

	typedef enum logic [3:0] {
		ST_HEAD1,
		ST_HEAD2,
		ST_LEN,
		ST_PER_H,
		ST_PER_L,
		ST_SA_H,
		ST_SA_L,
		ST_POINTS,
		ST_RESERVE,
		ST_EA_H,
		ST_EA_L,
		ST_CHECK,
		ST_EM_RD,
		ST_EM_OUT
	} state_t;

	state_t                         state_q;
	logic [lpp_pkg::POS_W-1:0]      pos_q;
	logic [1:0]                     sub_q;
	logic [lpp_pkg::PT_CW-1:0]      pts_q;
	logic [lpp_pkg::PT_AW-1:0]      idx_q;
	logic                           in_fire;
	logic [lpp_pkg::POS_W:0]        pos_next;
	logic                           pts_done;
	logic                           idx_last;

	assign in_ready = (state_q != ST_EM_RD) && (state_q != ST_EM_OUT) &&
		((state_q != ST_CHECK) || sts.out_free);
	assign in_fire  = in_valid && in_ready;
	assign pos_next = {1'b0, pos_q} + 1'b1;
	assign pts_done = ({1'b0, pts_q} + 1'b1) >= (lpp_pkg::PT_CW + 1)'(lpp_pkg::POINTS_PER_PACKET);
	assign idx_last = idx_q == lpp_pkg::PT_AW'(lpp_pkg::POINTS_PER_PACKET - 1);

	always_comb begin
		cmd           = '0;
		cmd.op        = lpp_pkg::OP_NONE;
		cmd.addr      = idx_q;
		cmd.last      = idx_last;
		case (state_q)
			ST_HEAD1: begin
				cmd.sum_begin = in_fire && sts.is_first;
			end
			ST_HEAD2: begin
				cmd.sum_add   = in_fire && sts.is_second;
				cmd.sum_begin = in_fire && !sts.is_second && sts.is_first;
			end
			ST_LEN: begin
				cmd.sum_add = in_fire;
			end
			ST_PER_H: begin
				cmd.sum_add = in_fire;
				cmd.op      = in_fire ? lpp_pkg::OP_PER_H : lpp_pkg::OP_NONE;
			end
			ST_PER_L: begin
				cmd.sum_add = in_fire;
				cmd.op      = in_fire ? lpp_pkg::OP_PER_L : lpp_pkg::OP_NONE;
			end
			ST_SA_H: begin
				cmd.sum_add = in_fire;
				cmd.op      = in_fire ? lpp_pkg::OP_SA_H : lpp_pkg::OP_NONE;
			end
			ST_SA_L: begin
				cmd.sum_add = in_fire;
				cmd.op      = in_fire ? lpp_pkg::OP_SA_L : lpp_pkg::OP_NONE;
			end
			ST_POINTS: begin
				cmd.sum_add = in_fire;
				cmd.addr    = pts_q[lpp_pkg::PT_AW-1:0];
				if (in_fire) begin
					case (sub_q)
						2'd0:    cmd.op = lpp_pkg::OP_DIST_H;
						2'd1:    cmd.op = lpp_pkg::OP_DIST_L;
						default: cmd.op = lpp_pkg::OP_POINT;
					endcase
				end
			end
			ST_RESERVE: begin
				cmd.sum_add = in_fire;
			end
			ST_EA_H: begin
				cmd.sum_add = in_fire;
				cmd.op      = in_fire ? lpp_pkg::OP_EA_H : lpp_pkg::OP_NONE;
			end
			ST_EA_L: begin
				cmd.sum_add = in_fire;
				cmd.op      = in_fire ? lpp_pkg::OP_EA_L : lpp_pkg::OP_NONE;
			end
			ST_CHECK: begin
				cmd.sum_clear = in_fire;
				cmd.op        = in_fire ? lpp_pkg::OP_CHECK : lpp_pkg::OP_NONE;
				cmd.bad       = in_fire && !sts.sum_ok;
			end
			ST_EM_RD: begin
				cmd.rd = 1'b1;
			end
			ST_EM_OUT: begin
				cmd.emit = sts.out_free;
			end
			default: begin
				cmd.op = lpp_pkg::OP_NONE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_HEAD1;
			pos_q   <= '0;
			sub_q   <= '0;
			pts_q   <= '0;
			idx_q   <= '0;
		end else begin
			case (state_q)
				ST_HEAD1: begin
					if (in_fire && sts.is_first) begin
						state_q <= ST_HEAD2;
						pos_q   <= lpp_pkg::POS_W'(1);
						pts_q   <= '0;
					end
				end
				ST_HEAD2: begin
					if (in_fire) begin
						if (sts.is_second) begin
							state_q <= ST_LEN;
							pos_q   <= lpp_pkg::POS_W'(2);
						end else if (sts.is_first) begin
							pos_q <= lpp_pkg::POS_W'(1);
							pts_q <= '0;
						end else begin
							state_q <= ST_HEAD1;
						end
					end
				end
				ST_LEN: begin
					if (in_fire) begin
						pos_q   <= pos_next[lpp_pkg::POS_W-1:0];
						state_q <= sts.len_ok ? ST_PER_H : ST_HEAD1;
					end
				end
				ST_PER_H: begin
					if (in_fire) begin
						pos_q   <= pos_next[lpp_pkg::POS_W-1:0];
						state_q <= ST_PER_L;
					end
				end
				ST_PER_L: begin
					if (in_fire) begin
						pos_q   <= pos_next[lpp_pkg::POS_W-1:0];
						state_q <= ST_SA_H;
					end
				end
				ST_SA_H: begin
					if (in_fire) begin
						pos_q   <= pos_next[lpp_pkg::POS_W-1:0];
						state_q <= ST_SA_L;
					end
				end
				ST_SA_L: begin
					if (in_fire) begin
						pos_q   <= pos_next[lpp_pkg::POS_W-1:0];
						pts_q   <= '0;
						sub_q   <= '0;
						state_q <= ST_POINTS;
					end
				end
				ST_POINTS: begin
					if (in_fire) begin
						pos_q <= pos_next[lpp_pkg::POS_W-1:0];
						case (sub_q)
							2'd0:    sub_q <= 2'd1;
							2'd1:    sub_q <= 2'd2;
							default: begin
								sub_q <= 2'd0;
								pts_q <= pts_q + 1'b1;
								if (pts_done) begin
									state_q <= (pos_next >= lpp_pkg::END_FIELD) ?
										ST_EA_H : ST_RESERVE;
								end
							end
						endcase
					end
				end
				ST_RESERVE: begin
					if (in_fire) begin
						pos_q <= pos_next[lpp_pkg::POS_W-1:0];
						if (pos_next >= lpp_pkg::END_FIELD) begin
							state_q <= ST_EA_H;
						end
					end
				end
				ST_EA_H: begin
					if (in_fire) begin
						pos_q   <= pos_next[lpp_pkg::POS_W-1:0];
						state_q <= ST_EA_L;
					end
				end
				ST_EA_L: begin
					if (in_fire) begin
						pos_q   <= pos_next[lpp_pkg::POS_W-1:0];
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					if (in_fire) begin
						pos_q   <= '0;
						idx_q   <= '0;
						state_q <= sts.sum_ok ? ST_EM_RD : ST_HEAD1;
					end
				end
				ST_EM_RD: begin
					state_q <= ST_EM_OUT;
				end
				ST_EM_OUT: begin
					if (sts.out_free) begin
						if (idx_last) begin
							state_q <= ST_HEAD1;
						end else begin
							idx_q   <= idx_q + 1'b1;
							state_q <= ST_EM_RD;
						end
					end
				end
				default: begin
					state_q <= ST_HEAD1;
				end
			endcase
		end
	end

endmodule

/* design/lpp_dp.sv */
// ----------------------------------------------------------------------------
// lpp_dp
// Field capture, checksum, point store, angle interpolation, range windows
// and the result register.
// ----------------------------------------------------------------------------
module lpp_dp (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [7:0]         rx_byte,
	input  logic               cfg_valid,
	input  logic [2:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	input  lpp_pkg::lpp_cmd_t  cmd,
	output lpp_pkg::lpp_sts_t  sts,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [4:0]         point_index,
	output logic [15:0]        point_angle,
	output logic [15:0]        point_distance,
	output logic [7:0]         point_intensity,
	output logic               in_range,
	output logic [15:0]        rotation_period,
	output logic               checksum_bad,
	output logic               last
);

	localparam int PROD_W = lpp_pkg::PT_AW + 16;

	logic [15:0] angle_low_q, angle_high_q, dist_low_q, dist_high_q;
	logic [7:0]  sum_q;
	logic [15:0] period_q;
	logic [7:0]  sa_hi_q, ea_hi_q;
	logic [15:0] sa_q, ea_q, span_q;
	logic [15:0] part_dist_q;
	logic [23:0] store_q [lpp_pkg::POINTS_PER_PACKET];
	logic [23:0] rd_s1;
	logic [PROD_W-1:0] prod_s1;
	logic [lpp_pkg::PT_AW-1:0] idx_s1;
	logic        out_valid_q;

	logic [16:0] sa_full, ea_full, span_up, span_dn;
	logic [16:0] ang_sum, ang_red;
	logic [15:0] ang;
	logic [15:0] rd_dist;
	logic        ok;

	assign sts.is_first  = rx_byte == lpp_pkg::HDR_FIRST;
	assign sts.is_second = rx_byte == lpp_pkg::HDR_SECOND;
	assign sts.len_ok    = rx_byte == lpp_pkg::LEN_BYTE;
	assign sts.sum_ok    = rx_byte == sum_q;
	assign sts.out_free  = !out_valid_q || out_ready;

	// modulo 36000 of a 16-bit angle needs one subtract at most
	assign sa_full = {1'b0, sa_hi_q, rx_byte};
	assign ea_full = {1'b0, ea_hi_q, rx_byte};
	assign span_up = {1'b0, ea_q} - {1'b0, sa_q};
	assign span_dn = {1'b0, ea_q} + lpp_pkg::ANGLE_WRAP - {1'b0, sa_q};

	assign ang_sum = {1'b0, sa_q} + 17'(prod_s1 / lpp_pkg::POINTS_PER_PACKET);
	assign ang_red = (ang_sum >= lpp_pkg::ANGLE_WRAP) ? ang_sum - lpp_pkg::ANGLE_WRAP : ang_sum;
	assign ang     = ang_red[15:0];
	assign rd_dist = rd_s1[23:8];
	assign ok      = (ang >= angle_low_q) && (ang <= angle_high_q) &&
		(rd_dist >= dist_low_q) && (rd_dist <= dist_high_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			angle_low_q  <= 16'd0;
			angle_high_q <= 16'd36000;
			dist_low_q   <= 16'd0;
			dist_high_q  <= 16'd20000;
		end else if (cfg_valid) begin
			case (cfg_index)
				lpp_pkg::CFG_ANGLE_LOW:  angle_low_q  <= cfg_data;
				lpp_pkg::CFG_ANGLE_HIGH: angle_high_q <= cfg_data;
				lpp_pkg::CFG_DIST_LOW:   dist_low_q   <= cfg_data;
				lpp_pkg::CFG_DIST_HIGH:  dist_high_q  <= cfg_data;
				default:                 angle_low_q  <= angle_low_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q       <= '0;
			period_q    <= '0;
			sa_hi_q     <= '0;
			ea_hi_q     <= '0;
			sa_q        <= '0;
			ea_q        <= '0;
			span_q      <= '0;
			part_dist_q <= '0;
		end else begin
			if (cmd.sum_begin) begin
				sum_q <= lpp_pkg::HDR_FIRST;
			end else if (cmd.sum_clear) begin
				sum_q <= '0;
			end else if (cmd.sum_add) begin
				sum_q <= sum_q + rx_byte;
			end
			case (cmd.op)
				lpp_pkg::OP_PER_H:  period_q <= {rx_byte, 8'd0};
				lpp_pkg::OP_PER_L:  period_q <= {period_q[15:8], rx_byte};
				lpp_pkg::OP_SA_H:   sa_hi_q <= rx_byte;
				lpp_pkg::OP_SA_L:   sa_q <= (sa_full >= lpp_pkg::ANGLE_WRAP) ?
					16'(sa_full - lpp_pkg::ANGLE_WRAP) : sa_full[15:0];
				lpp_pkg::OP_DIST_H: part_dist_q <= {rx_byte, 8'd0};
				lpp_pkg::OP_DIST_L: part_dist_q <= {part_dist_q[15:8], rx_byte};
				lpp_pkg::OP_EA_H:   ea_hi_q <= rx_byte;
				lpp_pkg::OP_EA_L:   ea_q <= (ea_full >= lpp_pkg::ANGLE_WRAP) ?
					16'(ea_full - lpp_pkg::ANGLE_WRAP) : ea_full[15:0];
				lpp_pkg::OP_CHECK:  span_q <= (ea_q >= sa_q) ? span_up[15:0] : span_dn[15:0];
				default:            span_q <= span_q;
			endcase
		end
	end

	// point store
	always_ff @(posedge clk) begin
		if (cmd.op == lpp_pkg::OP_POINT) begin
			store_q[cmd.addr] <= {part_dist_q, rx_byte};
		end
		if (cmd.rd) begin
			rd_s1   <= store_q[cmd.addr];
			prod_s1 <= PROD_W'(cmd.addr) * PROD_W'(span_q);
			idx_s1  <= cmd.addr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit || cmd.bad) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			point_index     <= 5'(idx_s1);
			point_angle     <= ang;
			point_distance  <= rd_dist;
			point_intensity <= ok ? rd_s1[7:0] : 8'd0;
			in_range        <= ok;
			rotation_period <= period_q;
			checksum_bad    <= 1'b0;
			last            <= cmd.last;
		end else if (cmd.bad) begin
			point_index     <= '0;
			point_angle     <= '0;
			point_distance  <= '0;
			point_intensity <= '0;
			in_range        <= 1'b0;
			rotation_period <= '0;
			checksum_bad    <= 1'b1;
			last            <= 1'b1;
		end
	end

	assign out_valid = out_valid_q;

endmodule

/* design/lidar_packet_point_parser.sv */
// ----------------------------------------------------------------------------
// lidar_packet_point_parser
// Byte-wise rangefinder packet parser with additive checksum; emits the
// interpolated, window-checked points of each good packet.
//
//   channel   handshake              payload
//   input     in_valid / in_ready    rx_byte
//   config    cfg_valid / cfg_ready  cfg_index, cfg_data
//   output    out_valid / out_ready  point_index .. last
//
// one cycle per byte while parsing; after a good checksum byte the input
// stalls while 32 points go out, each by a store read plus multiply, then
// interpolate and window check, waiting while out_ready holds a result.
// a bad checksum gives one flagged result from the checksum byte itself.
// the checksum byte waits while the result register is still full.
// reset returns to header hunt with the default windows; the point store
// is not cleared.
// ----------------------------------------------------------------------------
module lidar_packet_point_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  rx_byte,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [4:0]  point_index,
	output logic [15:0] point_angle,
	output logic [15:0] point_distance,
	output logic [7:0]  point_intensity,
	output logic        in_range,
	output logic [15:0] rotation_period,
	output logic        checksum_bad,
	output logic        last
);

	lpp_pkg::lpp_cmd_t cmd;
	lpp_pkg::lpp_sts_t sts;

	assign cfg_ready = 1'b1;

	lpp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	lpp_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.rx_byte         (rx_byte),
		.cfg_valid       (cfg_valid),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.cmd             (cmd),
		.sts             (sts),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.point_index     (point_index),
		.point_angle     (point_angle),
		.point_distance  (point_distance),
		.point_intensity (point_intensity),
		.in_range        (in_range),
		.rotation_period (rotation_period),
		.checksum_bad    (checksum_bad),
		.last            (last)
	);

	// no input transfer while points are being sent
	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit || cmd.rd) |-> !in_ready)
		else $error("input taken during point emission");

	// a packet rejected by its checksum gives a single zeroed last result
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && checksum_bad) |-> (last && !in_range && point_intensity == 8'd0))
		else $error("bad checksum result malformed");

	// the last point of a good packet is the final index
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && last && !checksum_bad) |->
		(point_index == 5'(lpp_pkg::POINTS_PER_PACKET - 1)))
		else $error("last flag on wrong point");

	// a new result is loaded only when the result register is free
	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit || cmd.bad) |-> (!out_valid || out_ready))
		else $error("result register overwritten");

endmodule
